@@ rtl/wgm_pkg.sv @@
// ----------------------------------------------------------------------------
// Wildcard glob matcher package
// Command codes, special pattern characters and the control bundle that the
// top level broadcasts to every matcher cell.
// ----------------------------------------------------------------------------
package wgm_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_TEXT   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  // Control broadcast to all cells for the word accepted in this cycle.
  typedef struct packed {
    logic       clear;        // drop the pattern and all prefix bits
    logic       rearm;        // finish: restart the text
    logic       append;       // store a pattern character in the selected cell
    logic       append_live;  // prefix bit before the appended character
    logic       text;         // advance all prefix bits by one text character
    logic [7:0] data;         // pattern or text character
  } cell_ctrl_t;

endpackage

@@ rtl/wgm_cell.sv @@
// ----------------------------------------------------------------------------
// Wildcard glob matcher cell
// Holds one pattern character and the live bit of the pattern prefix that
// ends at it, and updates that bit from its left neighbor on each text word.
// ----------------------------------------------------------------------------
module wgm_cell
  import wgm_pkg::*;
#(
  parameter bit IsFirst = 1'b0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       sel_i,        // this cell is the next free slot
  input  logic       prev_live_i,  // left neighbor's live bit before the update
  input  logic       prev_hit_i,   // left neighbor became live on a plain match
  input  logic       next_occ_i,   // right neighbor holds a character
  output logic       live_o,
  output logic       hit_o,
  output logic       occ_o,
  output logic       tail_o        // live bit of the last stored character
);

  logic       occ_q, occ_d;
  logic       live_q, live_d;
  logic [7:0] pat_q, pat_d;
  logic       is_star;

  assign is_star = (pat_q == STAR_CHAR);

  // A non-star position becomes live when its left neighbor was live and the
  // text character fits. Star runs are collapsed, so a star's left neighbor
  // is never a star and this hit is all a star needs from it.
  assign hit_o  = occ_q && !is_star && prev_live_i &&
                  ((pat_q == ANY_CHAR) || (pat_q == ctrl_i.data));
  assign live_o = live_q;
  assign occ_o  = occ_q;
  assign tail_o = occ_q && !next_occ_i && live_q;

  always_comb begin
    occ_d  = occ_q;
    live_d = live_q;
    pat_d  = pat_q;
    if (ctrl_i.clear) begin
      occ_d  = 1'b0;
      live_d = 1'b0;
    end else if (ctrl_i.rearm) begin
      // Only a leading star matches the empty text.
      live_d = IsFirst && occ_q && is_star;
    end else if (ctrl_i.append && sel_i) begin
      occ_d  = 1'b1;
      pat_d  = ctrl_i.data;
      live_d = (ctrl_i.data == STAR_CHAR) && ctrl_i.append_live;
    end else if (ctrl_i.text && occ_q) begin
      live_d = is_star ? (prev_hit_i || live_q) : hit_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 1'b0;
      live_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      live_q <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
  end

endmodule

@@ rtl/wildcard_glob_matcher_core.sv @@
// ----------------------------------------------------------------------------
// Wildcard glob matcher core
// Matches a streamed text against a stored glob pattern with '?' and '*'.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while its input is ready:
// pattern characters are appended with the append command (runs of '*' are
// folded into one), text characters follow with the text command, and a
// finish command yields one registered result word and restarts the
// text. A clear command forgets the pattern. The pattern lives in a row of
// PATTERN_MAX identical cells, one per pattern character; each cell keeps
// the live bit of the pattern prefix ending at its character and updates it
// from its left neighbor, so every position advances in the same cycle and
// the row takes one text character per cycle while the input is ready. A
// pattern longer than PATTERN_MAX sets a sticky overflow flag, reported as
// too_long with matched low, until the next clear. The result sits in an
// output register; the input stays ready while it is empty or being drained.
module wildcard_glob_matcher_core
  import wgm_pkg::*;
#(
  parameter int PATTERN_MAX = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] character
  input  logic [1:0] s_axis_tuser,   // [1:0] command
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] matched, [7:1] zero
  output logic       m_axis_tuser    // [0] too_long
);

  localparam int CntW = $clog2(PATTERN_MAX + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            empty_live_q, empty_live_d;
  logic            star_last_q, star_last_d;
  logic            ovf_q, ovf_d;
  logic            out_valid_q, out_valid_d;
  logic            matched_q, matched_d;
  logic            too_long_q, too_long_d;

  logic            in_fire;
  cmd_e            cmd;
  logic            is_star;
  logic            full;
  logic            tail_live;
  logic            append_live;
  cell_ctrl_t      ctrl;

  logic [PATTERN_MAX-1:0] sel;
  logic [PATTERN_MAX-1:0] live;
  logic [PATTERN_MAX-1:0] hit;
  logic [PATTERN_MAX-1:0] occ;
  logic [PATTERN_MAX-1:0] tail;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);
  assign is_star       = (s_axis_tdata == STAR_CHAR);
  assign full          = (count_q == CntW'(PATTERN_MAX));

  // Only the last stored character has its tail flag set, so the OR picks
  // the live bit of the whole pattern.
  assign tail_live   = |tail;
  assign append_live = (count_q == '0) ? empty_live_q : tail_live;

  always_comb begin
    ctrl             = '0;
    ctrl.data        = s_axis_tdata;
    ctrl.append_live = append_live;
    if (in_fire) begin
      unique case (cmd)
        CMD_APPEND: ctrl.append = !(is_star && star_last_q) && !full;
        CMD_TEXT:   ctrl.text   = 1'b1;
        CMD_FINISH: ctrl.rearm  = 1'b1;
        CMD_CLEAR:  ctrl.clear  = 1'b1;
        default:    ctrl        = ctrl;
      endcase
    end
  end

  // Sequencer state: pattern length, empty-prefix bit, star folding, overflow.
  always_comb begin
    count_d      = count_q;
    empty_live_d = empty_live_q;
    star_last_d  = star_last_q;
    ovf_d        = ovf_q;
    if (in_fire) begin
      unique case (cmd)
        CMD_APPEND: begin
          if (!(is_star && star_last_q)) begin
            if (full) begin
              ovf_d = 1'b1;
            end else begin
              count_d     = count_q + CntW'(1);
              star_last_d = is_star;
            end
          end
        end
        CMD_TEXT: begin
          empty_live_d = 1'b0;
        end
        CMD_FINISH: begin
          empty_live_d = 1'b1;
        end
        CMD_CLEAR: begin
          count_d      = '0;
          empty_live_d = 1'b1;
          star_last_d  = 1'b0;
          ovf_d        = 1'b0;
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  // Output register: loaded on finish, emptied when the sink takes the word.
  always_comb begin
    out_valid_d = out_valid_q;
    matched_d   = matched_q;
    too_long_d  = too_long_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && (cmd == CMD_FINISH)) begin
      out_valid_d = 1'b1;
      too_long_d  = ovf_q;
      matched_d   = !ovf_q && ((count_q == '0) ? empty_live_q : tail_live);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      empty_live_q <= 1'b1;
      star_last_q  <= 1'b0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      empty_live_q <= empty_live_d;
      star_last_q  <= star_last_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q  <= matched_d;
    too_long_q <= too_long_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, matched_q};
  assign m_axis_tuser  = too_long_q;

  // The cell row: cell j holds pattern character j.
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic prev_live;
    logic prev_hit;
    logic next_occ;

    assign sel[j] = (count_q == CntW'(j));

    if (j == 0) begin : g_head
      assign prev_live = empty_live_q;
      assign prev_hit  = 1'b0;
    end else begin : g_body
      assign prev_live = live[j-1];
      assign prev_hit  = hit[j-1];
    end

    if (j == PATTERN_MAX - 1) begin : g_end
      assign next_occ = 1'b0;
    end else begin : g_mid
      assign next_occ = occ[j+1];
    end

    wgm_cell #(
      .IsFirst (j == 0)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .sel_i       (sel[j]),
      .prev_live_i (prev_live),
      .prev_hit_i  (prev_hit),
      .next_occ_i  (next_occ),
      .live_o      (live[j]),
      .hit_o       (hit[j]),
      .occ_o       (occ[j]),
      .tail_o      (tail[j])
    );
  end

endmodule
